### src/crc8_frame_parser_macros.svh
// ----------------------------------------------------------------------------
// crc8_frame_parser_macros
// assertion macros for the deframer rtl
// ----------------------------------------------------------------------------
`ifndef CRC8_FRAME_PARSER_MACROS_SVH
`define CRC8_FRAME_PARSER_MACROS_SVH

`ifndef SYNTH
// checked only out of reset
`define CRCFP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("crcfp assertion failed");
// checked at every edge, reset included
`define CRCFP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("crcfp assertion failed");
`else
`define CRCFP_ASSERT(lbl, prop)
`define CRCFP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### src/crcfp_pkg.sv
// ----------------------------------------------------------------------------
// crcfp_pkg
// types, codes and the crc-8 byte step for the frame deframer
// ----------------------------------------------------------------------------
`default_nettype none

package crcfp_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [7:0] START_BYTE_RST = 8'h02;
  localparam logic [7:0] END_BYTE_RST   = 8'h03;

  // register indexes
  localparam logic CFG_START_BYTE = 1'b0;
  localparam logic CFG_END_BYTE   = 1'b1;

  // result kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  // frame status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CRC_ERR = 2'd1;
  localparam logic [1:0] ST_NO_END  = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_FUNC  = 3'd1,
    PH_COUNT = 3'd2,
    PH_DATA  = 3'd3,
    PH_CRC   = 3'd4,
    PH_END   = 3'd5
  } phase_e;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] func_code;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic       last_data;
    logic [7:0] data_count;
    logic [1:0] status;
  } result_t;

  // msb-first crc-8 over one byte
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### src/crcfp_deframe.sv
// ----------------------------------------------------------------------------
// crcfp_deframe
// frame state machine: hunts the start byte, tracks fields and crc
// ----------------------------------------------------------------------------
`default_nettype none

module crcfp_deframe (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic [7:0]        start_byte_i,
  input  wire logic [7:0]        end_byte_i,
  output crcfp_pkg::result_t     result_o
);

  crcfp_pkg::phase_e phase_q, phase_d;
  logic [7:0] func_q, func_d;
  logic [7:0] count_q, count_d;
  logic [7:0] pos_q, pos_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] rcrc_q, rcrc_d;

  logic       last_data;
  logic [7:0] crc_upd;
  logic [7:0] crc_fin;

  assign last_data = ({1'b0, pos_q} + 9'd1) >= {1'b0, count_q};
  assign crc_upd   = crcfp_pkg::crc_step(crc_q, rx_byte_i);
  assign crc_fin   = crcfp_pkg::crc_step(crc_q, end_byte_i);

  // next state
  always_comb begin
    phase_d = phase_q;
    func_d  = func_q;
    count_d = count_q;
    pos_d   = pos_q;
    crc_d   = crc_q;
    rcrc_d  = rcrc_q;
    if (step_i) begin
      unique case (phase_q)
        crcfp_pkg::PH_FUNC: begin
          func_d  = rx_byte_i;
          crc_d   = crc_upd;
          phase_d = crcfp_pkg::PH_COUNT;
        end
        crcfp_pkg::PH_COUNT: begin
          count_d = rx_byte_i;
          pos_d   = '0;
          crc_d   = crc_upd;
          phase_d = (rx_byte_i == 8'd0) ? crcfp_pkg::PH_CRC : crcfp_pkg::PH_DATA;
        end
        crcfp_pkg::PH_DATA: begin
          crc_d = crc_upd;
          if (last_data) begin
            phase_d = crcfp_pkg::PH_CRC;
          end else begin
            pos_d = pos_q + 8'd1;
          end
        end
        crcfp_pkg::PH_CRC: begin
          rcrc_d  = rx_byte_i;
          phase_d = crcfp_pkg::PH_END;
        end
        crcfp_pkg::PH_END: begin
          phase_d = crcfp_pkg::PH_HUNT;
        end
        default: begin
          phase_d = crcfp_pkg::PH_HUNT;
          if (rx_byte_i == start_byte_i) begin
            crc_d   = crcfp_pkg::crc_step(crcfp_pkg::CRC_INIT, rx_byte_i);
            pos_d   = '0;
            phase_d = crcfp_pkg::PH_FUNC;
          end
        end
      endcase
    end
  end

  // result word
  always_comb begin
    result_o            = '0;
    result_o.func_code  = func_q;
    result_o.data_count = count_q;
    unique case (phase_q)
      crcfp_pkg::PH_DATA: begin
        result_o.valid      = 1'b1;
        result_o.kind       = crcfp_pkg::KIND_DATA;
        result_o.data_byte  = rx_byte_i;
        result_o.data_index = pos_q;
        result_o.last_data  = last_data;
        result_o.status     = crcfp_pkg::ST_OK;
      end
      crcfp_pkg::PH_END: begin
        result_o.valid = 1'b1;
        result_o.kind  = crcfp_pkg::KIND_FRAME;
        if (crc_fin != rcrc_q) begin
          result_o.status = crcfp_pkg::ST_CRC_ERR;
        end else if (rx_byte_i != end_byte_i) begin
          result_o.status = crcfp_pkg::ST_NO_END;
        end else begin
          result_o.status = crcfp_pkg::ST_OK;
        end
      end
      default: begin
        result_o.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= crcfp_pkg::PH_HUNT;
      func_q  <= '0;
      count_q <= '0;
      pos_q   <= '0;
      crc_q   <= crcfp_pkg::CRC_INIT;
      rcrc_q  <= '0;
    end else begin
      phase_q <= phase_d;
      func_q  <= func_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      rcrc_q  <= rcrc_d;
    end
  end

endmodule

`default_nettype wire

### src/crc8_frame_parser.sv
// ----------------------------------------------------------------------------
// crc8_frame_parser
// byte-stream deframer with crc-8 (poly 0x31, init 0xff) frame check
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall | rx_byte
//  out     | output    | out_valid/out_stall | kind, func_code, data_byte,
//          |           |                     | data_index, last_data,
//          |           |                     | data_count, status
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
//  one word per cycle sustained while the output is not stalled; a word goes
//  input register -> result register
//  reset: hunting, start byte 0x02, end byte 0x03, crc 0xff
//  a stalled result holds its register; the input register keeps taking words
//  while the result register is free or being emptied
// ----------------------------------------------------------------------------
`default_nettype none

`include "crc8_frame_parser_macros.svh"

module crc8_frame_parser (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            kind_o,
  output logic [7:0]      func_code_o,
  output logic [7:0]      data_byte_o,
  output logic [7:0]      data_index_o,
  output logic            last_data_o,
  output logic [7:0]      data_count_o,
  output logic [1:0]      status_o
);

  logic [7:0] start_byte_q;
  logic [7:0] end_byte_q;

  logic       in_valid_q, in_valid_d;
  logic [7:0] rx_q;
  logic       out_valid_q, out_valid_d;
  crcfp_pkg::result_t res, res_q;

  logic in_load;
  logic out_free;
  logic advance;
  logic out_load;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !advance;
  assign in_load    = in_valid_i && !in_stall_o;
  assign out_load   = advance && res.valid;

  assign in_valid_d  = in_load || (in_valid_q && !advance);
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  crcfp_deframe u_deframe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .rx_byte_i    (rx_q),
    .start_byte_i (start_byte_q),
    .end_byte_i   (end_byte_q),
    .result_o     (res)
  );

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= crcfp_pkg::START_BYTE_RST;
      end_byte_q   <= crcfp_pkg::END_BYTE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        crcfp_pkg::CFG_START_BYTE: start_byte_q <= cfg_data_i;
        crcfp_pkg::CFG_END_BYTE:   end_byte_q   <= cfg_data_i;
        default:                   start_byte_q <= start_byte_q;
      endcase
    end
  end

  // handshake control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      rx_q <= rx_byte_i;
    end
    if (out_load) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = res_q.kind;
  assign func_code_o  = res_q.func_code;
  assign data_byte_o  = res_q.data_byte;
  assign data_index_o = res_q.data_index;
  assign last_data_o  = res_q.last_data;
  assign data_count_o = res_q.data_count;
  assign status_o     = res_q.status;

  `CRCFP_ASSERT_ALWAYS(a_stall_needs_word, !in_valid_q |-> !in_stall_o)
  `CRCFP_ASSERT(a_result_lands, out_load |=> out_valid_q)
  `CRCFP_ASSERT(a_status_code, out_valid_q |-> status_o <= crcfp_pkg::ST_NO_END)
  `CRCFP_ASSERT(a_data_no_status,
    (out_valid_q && kind_o == crcfp_pkg::KIND_DATA) |-> status_o == crcfp_pkg::ST_OK)
  `CRCFP_ASSERT(a_frame_clean,
    (out_valid_q && kind_o == crcfp_pkg::KIND_FRAME) |->
      (data_byte_o == 8'd0 && data_index_o == 8'd0 && !last_data_o))

endmodule

`default_nettype wire

### sim/crc8_frame_checker.sv
// ----------------------------------------------------------------------------
// crc8_frame_checker
// watches the byte and result channels of the deframer, runs its own frame
// parser over every accepted byte, with crc-8 over each frame, and compares each
// accepted result word field by field with the oldest predicted one
// ----------------------------------------------------------------------------
`default_nettype none

module crc8_frame_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  input  wire logic       in_stall_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_stall_i,
  input  wire logic       kind_i,
  input  wire logic [7:0] func_code_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic [7:0] data_index_i,
  input  wire logic       last_data_i,
  input  wire logic [7:0] data_count_i,
  input  wire logic [1:0] status_i,
  output int              fail_count_o,
  output int              pending_o
);

  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic       kind;
    logic [7:0] fcode;
    logic [7:0] dbyte;
    logic [7:0] dindex;
    logic       is_last;
    logic [7:0] dcount;
    logic [1:0] status;
  } deframed_t;

  crcfp_pkg::phase_e phase_q;
  logic [7:0] start_q;
  logic [7:0] end_q;
  logic [7:0] func_q;
  logic [7:0] count_q;
  logic [7:0] pos_q;
  logic [7:0] crc_q;
  logic [7:0] rcv_crc_q;

  deframed_t  deframed_q[$];
  deframed_t  due;

  // bit-serial crc-8, msb first
  function automatic logic [7:0] crc8_0x31(input logic [7:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c  = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ crcfp_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

  task automatic report(input string what, input logic [7:0] exp, input logic [7:0] act);
    if (exp !== act) begin
      fail_count_o++;
      if (fail_count_o <= PRINT_LIMIT) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp, act);
      end
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    deframed_t  r;
    logic [7:0] fin;
    logic       is_last;
    r = '0;
    case (phase_q)
      crcfp_pkg::PH_FUNC: begin
        func_q  = b;
        crc_q   = crc8_0x31(crc_q, b);
        phase_q = crcfp_pkg::PH_COUNT;
      end
      crcfp_pkg::PH_COUNT: begin
        count_q = b;
        pos_q   = 8'd0;
        crc_q   = crc8_0x31(crc_q, b);
        phase_q = (b == 8'd0) ? crcfp_pkg::PH_CRC : crcfp_pkg::PH_DATA;
      end
      crcfp_pkg::PH_DATA: begin
        is_last   = (9'(pos_q) + 9'd1) >= 9'(count_q);
        crc_q     = crc8_0x31(crc_q, b);
        r.kind    = crcfp_pkg::KIND_DATA;
        r.fcode   = func_q;
        r.dbyte   = b;
        r.dindex  = pos_q;
        r.is_last = is_last;
        r.dcount  = count_q;
        r.status  = crcfp_pkg::ST_OK;
        deframed_q.push_back(r);
        if (is_last) begin
          phase_q = crcfp_pkg::PH_CRC;
        end else begin
          pos_q = pos_q + 8'd1;
        end
      end
      crcfp_pkg::PH_CRC: begin
        rcv_crc_q = b;
        phase_q   = crcfp_pkg::PH_END;
      end
      crcfp_pkg::PH_END: begin
        fin     = crc8_0x31(crc_q, end_q);
        r.kind  = crcfp_pkg::KIND_FRAME;
        r.fcode = func_q;
        r.dcount = count_q;
        if (fin != rcv_crc_q) begin
          r.status = crcfp_pkg::ST_CRC_ERR;
        end else if (b != end_q) begin
          r.status = crcfp_pkg::ST_NO_END;
        end else begin
          r.status = crcfp_pkg::ST_OK;
        end
        deframed_q.push_back(r);
        phase_q = crcfp_pkg::PH_HUNT;
      end
      default: begin
        phase_q = crcfp_pkg::PH_HUNT;
        if (b == start_q) begin
          crc_q   = crc8_0x31(crcfp_pkg::CRC_INIT, b);
          pos_q   = 8'd0;
          phase_q = crcfp_pkg::PH_FUNC;
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      = crcfp_pkg::PH_HUNT;
      start_q      = crcfp_pkg::START_BYTE_RST;
      end_q        = crcfp_pkg::END_BYTE_RST;
      func_q       = 8'd0;
      count_q      = 8'd0;
      pos_q        = 8'd0;
      crc_q        = crcfp_pkg::CRC_INIT;
      rcv_crc_q    = 8'd0;
      deframed_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (deframed_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= PRINT_LIMIT) begin
            $display("%0t: unexpected result word, expected none, actual kind %0d data %0h",
                     $time, kind_i, data_byte_i);
          end
        end else begin
          due = deframed_q.pop_front();
          report("kind",       8'(due.kind),    8'(kind_i));
          report("func_code",  due.fcode,       func_code_i);
          report("data_byte",  due.dbyte,       data_byte_i);
          report("data_index", due.dindex,      data_index_i);
          report("last_data",  8'(due.is_last), 8'(last_data_i));
          report("data_count", due.dcount,      data_count_i);
          report("status",     8'(due.status),  8'(status_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        deframe_byte(rx_byte_i);
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          crcfp_pkg::CFG_START_BYTE: start_q = cfg_data_i;
          crcfp_pkg::CFG_END_BYTE:   end_q   = cfg_data_i;
          default: ;
        endcase
      end
      pending_o = deframed_q.size();
    end
  end

endmodule

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// deframer testbench: directed frames for the corner cases, then random
// frames, noise and broken frames under several start/end byte settings,
// with bursty input, random output stall and one long output hold
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_index_i;
  logic [7:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       kind_o;
  logic [7:0] func_code_o;
  logic [7:0] data_byte_o;
  logic [7:0] data_index_o;
  logic       last_data_o;
  logic [7:0] data_count_o;
  logic [1:0] status_o;

  int         fail_count;
  int         pending;
  int         idle_cycles = 0;
  int         burst_left  = 0;
  int         frame_bytes = 0;
  bit         hold_req    = 1'b0;
  bit         hold_done   = 1'b0;
  logic [7:0] cur_start;
  logic [7:0] cur_end;
  logic [7:0] payload_q[$];

  crc8_frame_parser DUT (.*);

  crc8_frame_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_i       (kind_o),
    .func_code_i  (func_code_o),
    .data_byte_i  (data_byte_o),
    .data_index_i (data_index_o),
    .last_data_i  (last_data_o),
    .data_count_i (data_count_o),
    .status_i     (status_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: stall pattern in segments, plus one long hold on request
  initial begin
    int   mode;
    int   len;
    logic s;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(5, 40);
        repeat (len) begin
          case (mode)
            0:       s = 1'b0;
            1:       s = ($urandom_range(0, 3) == 0);
            2:       s = ($urandom_range(0, 1) == 0);
            default: s = ($urandom_range(0, 4) != 0);
          endcase
          out_stall_i <= s;
          @(posedge clk_i);
        end
      end
    end
  end

  // one word on the byte channel, in bursts with random gaps
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
  endtask

  // frame around payload_q; crc_flip corrupts the crc byte
  task automatic send_frame(input logic [7:0] func, input logic [7:0] crc_flip,
                            input logic [7:0] end_slot);
    logic [7:0] crc;
    logic [7:0] n;
    n   = 8'(payload_q.size());
    crc = crcfp_pkg::crc_step(crcfp_pkg::CRC_INIT, cur_start);
    send_byte(cur_start);
    crc = crcfp_pkg::crc_step(crc, func);
    send_byte(func);
    crc = crcfp_pkg::crc_step(crc, n);
    send_byte(n);
    foreach (payload_q[i]) begin
      crc = crcfp_pkg::crc_step(crc, payload_q[i]);
      send_byte(payload_q[i]);
    end
    crc = crcfp_pkg::crc_step(crc, cur_end);
    send_byte(crc ^ crc_flip);
    send_byte(end_slot);
    frame_bytes += int'(n) + 5;
  endtask

  task automatic configure(input logic [7:0] s, input logic [7:0] e);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= crcfp_pkg::CFG_START_BYTE;
    cfg_data_i  <= s;
    @(posedge clk_i);
    cfg_index_i <= crcfp_pkg::CFG_END_BYTE;
    cfg_data_i  <= e;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_start   = s;
    cur_end     = e;
    burst_left  = 0;
  endtask

  task automatic run_traffic(input int target, input int hold_at);
    int         first;
    int         sel;
    int         n;
    logic [7:0] flip;
    logic [7:0] end_slot;
    first = frame_bytes;
    while (frame_bytes - first < target) begin
      if (hold_at >= 0 && frame_bytes - first >= hold_at) begin
        hold_req = 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        payload_q.delete();
        n = ($urandom_range(0, 29) == 0) ? $urandom_range(9, 64) : $urandom_range(0, 8);
        repeat (n) payload_q.push_back(8'($urandom));
        flip     = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        end_slot = ($urandom_range(0, 6) == 0) ? 8'($urandom) : cur_end;
        send_frame(8'($urandom), flip, end_slot);
      end else if (sel < 88) begin
        // line noise
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else begin
        // start byte followed by a short random tail
        n = $urandom_range(1, 6);
        send_byte(cur_start);
        repeat (n) send_byte(8'($urandom));
        frame_bytes += n + 1;
      end
    end
  endtask

  initial begin
    logic [7:0] r;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= crcfp_pkg::CFG_START_BYTE;
    cfg_data_i  <= 8'h00;
    in_valid_i  <= 1'b0;
    rx_byte_i   <= 8'h00;
    cur_start   = crcfp_pkg::START_BYTE_RST;
    cur_end     = crcfp_pkg::END_BYTE_RST;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // dropped while hunting
    send_byte(8'h00);
    send_byte(8'hFF);
    // zero count, good frame
    payload_q = {};
    send_frame(8'hFF, 8'h00, cur_end);
    // wrong end byte that equals the start byte
    payload_q = {8'hFF};
    send_frame(8'h00, 8'h00, cur_start);
    // crc and end byte both wrong
    payload_q = {8'h00, 8'h80};
    send_frame(8'h5A, 8'h01, 8'hFF);
    // crc wrong only
    payload_q = {8'h7F};
    send_frame(8'hA5, 8'h80, cur_end);

    configure(8'h00, 8'hFF);
    run_traffic(60, -1);

    configure(8'hFF, 8'h00);
    payload_q.delete();
    repeat (255) payload_q.push_back(8'($urandom));
    send_frame(8'($urandom), 8'h00, cur_end);
    run_traffic(100, 30);

    // register write in the middle of a frame
    send_byte(cur_start);
    send_byte(8'($urandom));
    send_byte(8'd1);
    r = 8'($urandom);
    configure(r, r);
    repeat (3) send_byte(8'($urandom));
    run_traffic(50, -1);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
